// ===== hw/rtl/flt_pkg.sv =====
`timescale 1ns / 1ps

package flt_pkg;

    // table geometry
    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    // field widths
    localparam int OP_W     = 2;
    localparam int ADDR_W   = 64;
    localparam int TIME_W   = 32;
    localparam int COUNT_W  = 8;
    localparam int THR_W    = 8;
    localparam int PERIOD_W = 16;
    localparam int SLOT_W   = 6;

    // stream packing
    localparam int IN_BITS   = OP_W + 2 * ADDR_W + TIME_W;
    localparam int S_TDATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS  = 2 + SLOT_W;
    localparam int M_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam int OP_LSB    = 0;
    localparam int UPPER_LSB = OP_LSB + OP_W;
    localparam int LOWER_LSB = UPPER_LSB + ADDR_W;
    localparam int NOW_LSB   = LOWER_LSB + ADDR_W;

    // configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_FAIL_THRESHOLD = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT_PERIOD = CFG_IDX_W'(1);

    localparam logic [THR_W-1:0]    THR_RESET    = THR_W'(5);
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(300);

    typedef enum logic [OP_W-1:0] {
        OP_CHECK  = 2'd0,
        OP_RECORD = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FETCH,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  addr_upper;
        logic [ADDR_W-1:0]  addr_lower;
        logic [COUNT_W-1:0] fails;
        logic [TIME_W-1:0]  fail_stamp;
        logic [TIME_W-1:0]  lock_end;
    } entry_t;

    typedef struct packed {
        logic load_req;
        logic scan_rd;
        logic fetch_rd;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic scan_last;
    } sts_t;

endpackage

// ===== hw/rtl/failure_lockout_table.sv =====
`timescale 1ns / 1ps

// failure lockout table: keeps a table of TABLE_ENTRIES client entries keyed
// by a 128-bit client address and serves one request per input item: check
// for an active lockout (an expired one is cleared), record a failure
// (matching entry, else first empty slot, else the entry with the oldest
// last failure; the count saturates at 255 and reaching fail_threshold arms a
// lockout until now plus lockout_period, capped at the largest time) or clear
// the entry. Every item gives exactly one result item. Each request walks the
// whole table through the single read port of the entry memory, one entry per
// cycle, then re-reads the chosen slot and writes it back; the write-back
// waits while an earlier result is still unread, and the next item is taken
// only after it. A finished result waits in an output register, so the next
// item is taken while it is still unread. Valid bits are cleared at reset, so
// the table is usable at once, with no clearing pass. Registers are written
// through the cfg channel (index 0 fail_threshold, index 1 lockout_period);
// the user must write them only while no item is in flight, as the block
// itself does not enforce it.

module failure_lockout_table (
    input  logic                             aclk,
    input  logic                             aresetn,
    // request items
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // operation, client_addr_upper, client_addr_lower, now_seconds, zero pad
    input  logic [flt_pkg::S_TDATA_W-1:0]    s_tdata,
    // result items
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // locked_out, matched, slot_used
    output logic [flt_pkg::M_TDATA_W-1:0]    m_tdata,
    // register writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [flt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [flt_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import flt_pkg::*;

    cmd_t                cmd;
    sts_t                sts;
    logic [THR_W-1:0]    fail_threshold;
    logic [PERIOD_W-1:0] lockout_period;
    logic [OUT_BITS-1:0] out_data;

    // register block
    flt_cfg u_cfg (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_threshold (fail_threshold),
        .lockout_period (lockout_period)
    );

    // sequencer: accept, scan, drain, fetch, commit
    flt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // entry memory, scan compare and update logic
    flt_dpath u_dpath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .sts               (sts),
        .operation         (s_tdata[OP_LSB +: OP_W]),
        .client_addr_upper (s_tdata[UPPER_LSB +: ADDR_W]),
        .client_addr_lower (s_tdata[LOWER_LSB +: ADDR_W]),
        .now_seconds       (s_tdata[NOW_LSB +: TIME_W]),
        .fail_threshold    (fail_threshold),
        .lockout_period    (lockout_period),
        .out_data          (out_data)
    );

    // result padded up to whole bytes
    assign m_tdata = M_TDATA_W'(out_data);

endmodule

// ===== hw/rtl/flt_cfg.sv =====
`timescale 1ns / 1ps

module flt_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [flt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [flt_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic [flt_pkg::THR_W-1:0]        fail_threshold,
    output logic [flt_pkg::PERIOD_W-1:0]     lockout_period
);
    import flt_pkg::*;

    logic [THR_W-1:0]    thr_reg;
    logic [PERIOD_W-1:0] period_reg;

    assign cfg_ready      = 1'b1;
    assign fail_threshold = thr_reg;
    assign lockout_period = period_reg;

    // writes to unknown indices are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg    <= THR_RESET;
            period_reg <= PERIOD_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_FAIL_THRESHOLD: thr_reg    <= cfg_data[THR_W-1:0];
                CFG_LOCKOUT_PERIOD: period_reg <= cfg_data[PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

// ===== hw/rtl/flt_ctrl.sv =====
`timescale 1ns / 1ps

module flt_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    output flt_pkg::cmd_t cmd,
    input  flt_pkg::sts_t sts
);
    import flt_pkg::*;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;

    // output register free, or emptied at this edge
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_tvalid) state_next = ST_SCAN;
            ST_SCAN:   if (sts.scan_last) state_next = ST_DRAIN;
            ST_DRAIN:  state_next = ST_FETCH;
            ST_FETCH:  state_next = ST_COMMIT;
            ST_COMMIT: if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready     = 1'b0;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready     = 1'b1;
                cmd.load_req = s_tvalid;
            end
            ST_SCAN:   cmd.scan_rd  = 1'b1;
            ST_DRAIN:  ;
            ST_FETCH:  cmd.fetch_rd = 1'b1;
            ST_COMMIT: cmd.commit   = out_free;
            default:   ;
        endcase
    end

    always_comb begin
        if (cmd.commit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

// ===== hw/rtl/flt_dpath.sv =====
`timescale 1ns / 1ps

module flt_dpath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  flt_pkg::cmd_t                   cmd,
    output flt_pkg::sts_t                   sts,
    input  logic [flt_pkg::OP_W-1:0]        operation,
    input  logic [flt_pkg::ADDR_W-1:0]      client_addr_upper,
    input  logic [flt_pkg::ADDR_W-1:0]      client_addr_lower,
    input  logic [flt_pkg::TIME_W-1:0]      now_seconds,
    input  logic [flt_pkg::THR_W-1:0]       fail_threshold,
    input  logic [flt_pkg::PERIOD_W-1:0]    lockout_period,
    output logic [flt_pkg::OUT_BITS-1:0]    out_data
);
    import flt_pkg::*;

    // request held for the whole scan
    logic [OP_W-1:0]   req_op_reg;
    logic [ADDR_W-1:0] req_upper_reg;
    logic [ADDR_W-1:0] req_lower_reg;
    logic [TIME_W-1:0] req_now_reg;

    // entry table and its valid bits
    entry_t             mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] valid_reg;
    entry_t             rd_entry_reg;
    logic               rd_vld_reg;

    // scan address and compare stage
    logic [IDX_W-1:0]   scan_idx_reg;
    logic               cmp_pend_reg;
    logic [IDX_W-1:0]   cmp_idx_reg;

    // scan results
    logic               hit_found_reg;
    logic [IDX_W-1:0]   hit_idx_reg;
    logic               free_found_reg;
    logic [IDX_W-1:0]   free_idx_reg;
    logic [TIME_W:0]    stalest_reg;
    logic [IDX_W-1:0]   oldest_idx_reg;

    logic [OUT_BITS-1:0] out_data_reg;

    logic [IDX_W-1:0]   pick_idx;
    logic [IDX_W-1:0]   rd_addr;
    logic               mem_re;
    logic               rd_match;
    logic [TIME_W-1:0]  rd_age;
    logic               rd_older;

    entry_t             rec_base;
    logic [COUNT_W-1:0] rec_count;
    logic [TIME_W:0]    rec_sum;
    logic [TIME_W-1:0]  rec_until;
    logic [TIME_W-1:0]  rec_lock;

    entry_t             wr_entry;
    logic               mem_we;
    logic               vld_we;
    logic               vld_wdata;
    logic               res_locked;
    logic               res_matched;
    logic [SLOT_W-1:0]  res_slot;

    assign sts.scan_last = (scan_idx_reg == IDX_W'(TABLE_ENTRIES - 1));
    assign out_data      = out_data_reg;

    // slot priority: match, first free, oldest
    assign pick_idx = hit_found_reg  ? hit_idx_reg  :
                      free_found_reg ? free_idx_reg : oldest_idx_reg;
    assign rd_addr  = cmd.scan_rd ? scan_idx_reg : pick_idx;
    assign mem_re   = cmd.scan_rd || cmd.fetch_rd;

    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            req_op_reg    <= operation;
            req_upper_reg <= client_addr_upper;
            req_lower_reg <= client_addr_lower;
            req_now_reg   <= now_seconds;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[pick_idx] <= wr_entry;
        end
        if (mem_re) begin
            rd_entry_reg <= mem[rd_addr];
        end
        if (cmd.scan_rd) begin
            cmp_idx_reg <= scan_idx_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_vld_reg   <= 1'b0;
            cmp_pend_reg <= 1'b0;
            scan_idx_reg <= '0;
        end else begin
            if (vld_we) begin
                valid_reg[pick_idx] <= vld_wdata;
            end
            if (mem_re) begin
                rd_vld_reg <= valid_reg[rd_addr];
            end
            cmp_pend_reg <= cmd.scan_rd;
            if (cmd.load_req) begin
                scan_idx_reg <= '0;
            end else if (cmd.scan_rd) begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
            end
        end
    end

    // compare stage, one entry per cycle
    assign rd_match = rd_vld_reg && (rd_entry_reg.addr_upper == req_upper_reg)
                      && (rd_entry_reg.addr_lower == req_lower_reg);
    assign rd_age   = rd_vld_reg ? rd_entry_reg.fail_stamp : '0;
    assign rd_older = ({1'b0, rd_age} < stalest_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
        end else if (cmd.load_req) begin
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
        end else if (cmp_pend_reg) begin
            if (rd_match && !hit_found_reg) begin
                hit_found_reg <= 1'b1;
            end
            if (!rd_vld_reg && !free_found_reg) begin
                free_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            stalest_reg    <= {1'b0, now_seconds} + 1'b1;
            oldest_idx_reg <= '0;
        end else if (cmp_pend_reg) begin
            if (rd_match && !hit_found_reg) begin
                hit_idx_reg <= cmp_idx_reg;
            end
            if (!rd_vld_reg && !free_found_reg) begin
                free_idx_reg <= cmp_idx_reg;
            end
            if (rd_older) begin
                stalest_reg    <= {1'b0, rd_age};
                oldest_idx_reg <= cmp_idx_reg;
            end
        end
    end

    // record failure: fresh slots start from a wiped entry
    assign rec_base  = hit_found_reg ? rd_entry_reg : '0;
    assign rec_count = (rec_base.fails == '1) ? rec_base.fails
                                              : rec_base.fails + 1'b1;
    assign rec_sum   = {1'b0, req_now_reg} + (TIME_W + 1)'(lockout_period);
    assign rec_until = rec_sum[TIME_W] ? '1 : rec_sum[TIME_W-1:0];
    assign rec_lock  = (rec_count >= fail_threshold) ? rec_until : rec_base.lock_end;

    always_comb begin
        wr_entry    = rd_entry_reg;
        mem_we      = 1'b0;
        vld_we      = 1'b0;
        vld_wdata   = 1'b0;
        res_locked  = 1'b0;
        res_matched = 1'b0;
        res_slot    = '0;
        unique case (op_t'(req_op_reg))
            OP_CHECK: begin
                if (hit_found_reg) begin
                    res_matched = 1'b1;
                    res_slot    = SLOT_W'(pick_idx);
                    if (rd_entry_reg.lock_end > req_now_reg) begin
                        res_locked = 1'b1;
                    end else if (rd_entry_reg.lock_end != '0) begin
                        // expired lockout
                        wr_entry.fails    = '0;
                        wr_entry.lock_end = '0;
                        mem_we            = cmd.commit;
                    end
                end
            end
            OP_RECORD: begin
                wr_entry.addr_upper = req_upper_reg;
                wr_entry.addr_lower = req_lower_reg;
                wr_entry.fails      = rec_count;
                wr_entry.fail_stamp = req_now_reg;
                wr_entry.lock_end   = rec_lock;
                mem_we              = cmd.commit;
                vld_we              = cmd.commit;
                vld_wdata           = 1'b1;
                res_matched         = hit_found_reg;
                res_slot            = SLOT_W'(pick_idx);
            end
            OP_CLEAR: begin
                if (hit_found_reg) begin
                    res_matched = 1'b1;
                    res_slot    = SLOT_W'(pick_idx);
                    vld_we      = cmd.commit;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_data_reg <= {res_slot, res_matched, res_locked};
        end
    end

endmodule

// ===== hw/rtl/flt_checker.sv =====
`timescale 1ns / 1ps

module flt_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [flt_pkg::M_TDATA_W-1:0]  m_tdata
);
    import flt_pkg::*;

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // a lockout is only reported for a matched entry
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && !m_tdata[1]))
        else $error("locked_out without matched");

    // one item at a time: the scan follows every acceptance
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item accepted during scan");

    // a new result appears only as the block returns to idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> s_tready)
        else $error("result raised while busy");

endmodule

bind failure_lockout_table flt_checker u_flt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/sv/failure_lockout_table_tb.sv =====
`timescale 1ns / 1ps

module failure_lockout_table_tb;

    import flt_pkg::*;

    // opcode three is not an operation: the block answers with all fields zero
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
    localparam int POOL_SIZE   = 96;   // more clients than slots, so eviction happens
    localparam int PHASE_ITEMS = 280;
    localparam int NUM_PHASES  = 5;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] upper;
        logic [ADDR_W-1:0] lower;
        logic [TIME_W-1:0] now;
    } lock_req_t;

    typedef struct packed {
        logic              locked_out;
        logic              matched;
        logic [SLOT_W-1:0] slot_used;
    } lock_res_t;

    // directed row: request plus an answer typed in where it is obvious
    typedef struct packed {
        lock_req_t req;
        logic      known;
        lock_res_t res;
    } dir_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // own copy of the client table and the registers
    logic                 ent_valid [TABLE_ENTRIES];
    logic [ADDR_W-1:0]    ent_upper [TABLE_ENTRIES];
    logic [ADDR_W-1:0]    ent_lower [TABLE_ENTRIES];
    logic [COUNT_W-1:0]   ent_count [TABLE_ENTRIES];
    logic [TIME_W-1:0]    ent_last  [TABLE_ENTRIES];
    logic [TIME_W-1:0]    ent_until [TABLE_ENTRIES];
    logic [THR_W-1:0]     fail_threshold;
    logic [PERIOD_W-1:0]  lockout_period;

    lock_res_t            pending_results [$];
    logic [2*ADDR_W-1:0]  client_pool [POOL_SIZE];
    logic [TIME_W-1:0]    cur_time;

    int  result_mismatches;
    int  results_checked;
    int  lockouts_seen;
    int  requests_sent;
    int  records_sent;
    int  stall_left;
    bit  idle_enable;

    failure_lockout_table i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 10 ns clock
    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    function automatic void wipe_slot(input int i);
        ent_valid[i] = 1'b0;
        ent_upper[i] = '0;
        ent_lower[i] = '0;
        ent_count[i] = '0;
        ent_last[i]  = '0;
        ent_until[i] = '0;
    endfunction

    // first valid entry holding this address, -1 when none
    function automatic int find_client(input logic [ADDR_W-1:0] upper,
                                       input logic [ADDR_W-1:0] lower);
        for (int i = 0; i < TABLE_ENTRIES; i++)
            if (ent_valid[i] && ent_upper[i] == upper && ent_lower[i] == lower)
                return i;
        return -1;
    endfunction

    // applies one request to the table copy and returns the answer it gives
    function automatic lock_res_t apply_request(input lock_req_t r);
        lock_res_t       res;
        int              hit;
        int              slot;
        int              oldest;
        logic [TIME_W:0] stalest_stamp;
        logic [TIME_W:0] lock_sum;
        res  = '0;
        hit  = find_client(r.upper, r.lower);
        case (r.op)
            OP_CHECK: begin
                if (hit >= 0) begin
                    res.matched   = 1'b1;
                    res.slot_used = SLOT_W'(hit);
                    if (ent_until[hit] > r.now) begin
                        res.locked_out = 1'b1;
                    end else if (ent_until[hit] != '0) begin
                        // lockout has run out: forget the failures
                        ent_count[hit] = '0;
                        ent_until[hit] = '0;
                    end
                end
            end
            OP_RECORD: begin
                slot          = -1;
                oldest        = 0;
                stalest_stamp = {1'b0, r.now} + 1'b1;
                if (hit >= 0) begin
                    slot        = hit;
                    res.matched = 1'b1;
                end else begin
                    // first free slot, else the stalest last failure not after now
                    for (int i = 0; i < TABLE_ENTRIES; i++) begin
                        if (!ent_valid[i] && slot < 0)
                            slot = i;
                        if ({1'b0, ent_last[i]} < stalest_stamp) begin
                            stalest_stamp = {1'b0, ent_last[i]};
                            oldest        = i;
                        end
                    end
                    if (slot < 0)
                        slot = oldest;
                    wipe_slot(slot);
                    ent_valid[slot] = 1'b1;
                    ent_upper[slot] = r.upper;
                    ent_lower[slot] = r.lower;
                end
                if (ent_count[slot] != {COUNT_W{1'b1}})
                    ent_count[slot] = ent_count[slot] + 1'b1;
                ent_last[slot] = r.now;
                if (ent_count[slot] >= fail_threshold) begin
                    lock_sum = {1'b0, r.now} + (TIME_W + 1)'(lockout_period);
                    ent_until[slot] = lock_sum[TIME_W] ? {TIME_W{1'b1}}
                                                       : lock_sum[TIME_W-1:0];
                end
                res.slot_used = SLOT_W'(slot);
            end
            OP_CLEAR: begin
                if (hit >= 0) begin
                    res.matched   = 1'b1;
                    res.slot_used = SLOT_W'(hit);
                    wipe_slot(hit);
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic logic [S_TDATA_W-1:0] pack_request(input lock_req_t r);
        logic [S_TDATA_W-1:0] d;
        d = '0;
        d[OP_LSB    +: OP_W]   = r.op;
        d[UPPER_LSB +: ADDR_W] = r.upper;
        d[LOWER_LSB +: ADDR_W] = r.lower;
        d[NOW_LSB   +: TIME_W] = r.now;
        return d;
    endfunction

    // drives one request, waits for it to be taken, queues the answer;
    // tvalid stays high so a follow-on item with no random gap goes out on the next falling edge
    task automatic push_request(input lock_req_t r, input logic known,
                                input lock_res_t typed);
        int        gap;
        lock_res_t want;
        gap = 0;
        if (idle_enable && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 6);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pack_request(r);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        want = apply_request(r);
        if (known)
            want = typed;
        pending_results.push_back(want);
        requests_sent++;
        if (r.op == OP_RECORD)
            records_sent++;
    endtask

    // sender holds off until every answer is back, block is then idle
    task automatic wait_for_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0]  idx,
                                  input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_FAIL_THRESHOLD: fail_threshold = val[THR_W-1:0];
            CFG_LOCKOUT_PERIOD: lockout_period = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // mostly clients from a pool, some near misses on one bit, some strangers;
    // time creeps forward with the odd jump anywhere or back towards zero
    function automatic lock_req_t random_request();
        lock_req_t r;
        int        pick;
        int        k;
        pick = $urandom_range(0, 99);
        if (pick < 32)
            r.op = OP_CHECK;
        else if (pick < 85)
            r.op = OP_RECORD;
        else if (pick < 97)
            r.op = OP_CLEAR;
        else
            r.op = OP_SPARE;
        pick = $urandom_range(0, 99);
        if (pick < 20)
            k = $urandom_range(0, 3);
        else
            k = $urandom_range(0, POOL_SIZE - 1);
        {r.upper, r.lower} = client_pool[k];
        if (pick >= 94 && pick < 97)
            {r.upper, r.lower} = client_pool[k] ^ ((128'd1) << $urandom_range(0, 127));
        else if (pick >= 97)
            {r.upper, r.lower} = {$urandom, $urandom, $urandom, $urandom};
        cur_time = cur_time + $urandom_range(0, 3);
        pick = $urandom_range(0, 99);
        if (pick < 3)
            r.now = $urandom;
        else if (pick < 5)
            r.now = $urandom_range(0, 255);
        else
            r.now = cur_time;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // result side: stall bursts and checking
    // ------------------------------------------------------------------

    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (idle_enable && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 5);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        lock_res_t got;
        lock_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.locked_out = m_tdata[0];
            got.matched    = m_tdata[1];
            got.slot_used  = m_tdata[2 +: SLOT_W];
            if (got.locked_out)
                lockouts_seen++;
            if (pending_results.size() == 0) begin
                result_mismatches++;
                if (result_mismatches <= 10)
                    $display("unexpected result item: locked_out %0b matched %0b slot %0d",
                             got.locked_out, got.matched, got.slot_used);
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (got != want) begin
                    result_mismatches++;
                    if (result_mismatches <= 10) begin
                        $display("result %0d: expected locked_out %0b matched %0b slot %0d",
                                 results_checked, want.locked_out, want.matched,
                                 want.slot_used);
                        $display("    actual locked_out %0b matched %0b slot %0d",
                                 got.locked_out, got.matched, got.slot_used);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial begin
        dir_row_t             rows [25];
        logic [ADDR_W-1:0]    ones;
        logic [ADDR_W-1:0]    alt;
        logic [ADDR_W-1:0]    hot_upper;
        logic [ADDR_W-1:0]    hot_lower;
        logic [THR_W-1:0]     ph_thr [NUM_PHASES];
        logic [PERIOD_W-1:0]  ph_period [NUM_PHASES];
        logic [TIME_W-1:0]    ph_base [NUM_PHASES];
        lock_req_t            r;

        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        stall_left        = 0;
        idle_enable       = 1'b1;
        result_mismatches = 0;
        results_checked   = 0;
        lockouts_seen     = 0;
        requests_sent     = 0;
        records_sent      = 0;
        cur_time          = '0;
        fail_threshold    = THR_RESET;
        lockout_period    = PERIOD_RESET;
        for (int i = 0; i < TABLE_ENTRIES; i++)
            wipe_slot(i);
        for (int i = 0; i < POOL_SIZE; i++)
            client_pool[i] = {$urandom, $urandom, $urandom, $urandom};

        ones = {ADDR_W{1'b1}};
        alt  = {(ADDR_W/2){2'b10}};

        // reset register values: threshold 5, period 300
        // a = all ones, b = all zero, c and d = alternating bit patterns
        rows = '{
            // empty table: nothing matches, spare opcode answers zero
            '{'{OP_CHECK,  ones, ones, 32'd100},         1'b1, '{1'b0, 1'b0, 6'd0}},
            '{'{OP_CLEAR,  '0,   '0,   32'd0},           1'b1, '{1'b0, 1'b0, 6'd0}},
            '{'{OP_SPARE,  ones, ones, 32'hFFFF_FFFF},   1'b1, '{1'b0, 1'b0, 6'd0}},
            // a takes slot 0, b slot 1
            '{'{OP_RECORD, ones, ones, 32'd0},           1'b1, '{1'b0, 1'b0, 6'd0}},
            '{'{OP_RECORD, '0,   '0,   32'd1},           1'b1, '{1'b0, 1'b0, 6'd1}},
            // a reaches five failures at time 5, locked until 305
            '{'{OP_RECORD, ones, ones, 32'd2},           1'b1, '{1'b0, 1'b1, 6'd0}},
            '{'{OP_RECORD, ones, ones, 32'd3},           1'b1, '{1'b0, 1'b1, 6'd0}},
            '{'{OP_RECORD, ones, ones, 32'd4},           1'b1, '{1'b0, 1'b1, 6'd0}},
            '{'{OP_RECORD, ones, ones, 32'd5},           1'b1, '{1'b0, 1'b1, 6'd0}},
            '{'{OP_CHECK,  ones, ones, 32'd304},         1'b1, '{1'b1, 1'b1, 6'd0}},
            // lockout ends exactly at its time and is wiped
            '{'{OP_CHECK,  ones, ones, 32'd305},         1'b1, '{1'b0, 1'b1, 6'd0}},
            '{'{OP_RECORD, ones, ones, 32'd306},         1'b0, '0},
            '{'{OP_CHECK,  ones, ones, 32'd307},         1'b1, '{1'b0, 1'b1, 6'd0}},
            // c near the end of time: lockout saturates at the largest time
            '{'{OP_RECORD, alt,  ~alt, 32'hFFFF_FFF0},   1'b1, '{1'b0, 1'b0, 6'd2}},
            '{'{OP_RECORD, alt,  ~alt, 32'hFFFF_FFFF},   1'b0, '0},
            '{'{OP_RECORD, alt,  ~alt, 32'hFFFF_FFFF},   1'b0, '0},
            '{'{OP_RECORD, alt,  ~alt, 32'hFFFF_FFFF},   1'b0, '0},
            '{'{OP_RECORD, alt,  ~alt, 32'hFFFF_FFFF},   1'b1, '{1'b0, 1'b1, 6'd2}},
            '{'{OP_CHECK,  alt,  ~alt, 32'hFFFF_FFFE},   1'b1, '{1'b1, 1'b1, 6'd2}},
            '{'{OP_CHECK,  alt,  ~alt, 32'hFFFF_FFFF},   1'b1, '{1'b0, 1'b1, 6'd2}},
            // clearing b frees slot 1 for the next newcomer
            '{'{OP_CLEAR,  '0,   '0,   32'd7},           1'b1, '{1'b0, 1'b1, 6'd1}},
            '{'{OP_RECORD, ~alt, alt,  32'd8},           1'b1, '{1'b0, 1'b0, 6'd1}},
            '{'{OP_SPARE,  ~alt, alt,  32'd9},           1'b1, '{1'b0, 1'b0, 6'd0}},
            '{'{OP_CLEAR,  ~alt, alt,  32'd10},          1'b1, '{1'b0, 1'b1, 6'd1}},
            '{'{OP_CHECK,  ~alt, alt,  32'd11},          1'b1, '{1'b0, 1'b0, 6'd0}}
        };

        // register settings per random phase, extremes included
        ph_thr[0] = 8'd1;                          ph_period[0] = 16'hFFFF;
        ph_base[0] = $urandom;
        ph_thr[1] = 8'd255;                        ph_period[1] = 16'd1;
        ph_base[1] = 32'd1000;
        ph_thr[2] = 8'd0;                          ph_period[2] = 16'd0;
        ph_base[2] = $urandom;
        ph_thr[3] = THR_W'($urandom_range(2, 8));  ph_period[3] = PERIOD_W'($urandom_range(1, 600));
        ph_base[3] = 32'hFFFF_FF00;           // time wraps past the top here
        ph_thr[4] = THR_W'($urandom_range(2, 6));  ph_period[4] = PERIOD_W'($urandom_range(20, 300));
        ph_base[4] = $urandom;

        // reset held low at the start, released on a falling edge
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed part runs on the reset register values
        foreach (rows[i])
            push_request(rows[i].req, rows[i].known, rows[i].res);
        wait_for_results();

        for (int p = 0; p < NUM_PHASES; p++) begin
            // registers only change with the block idle
            write_register(CFG_FAIL_THRESHOLD, {8'($urandom), ph_thr[p]});
            write_register(CFG_LOCKOUT_PERIOD, ph_period[p]);
            if (p == 2)
                write_register(CFG_IDX_W'($urandom_range(CFG_LOCKOUT_PERIOD + 1, 255)),
                               CFG_DATA_W'($urandom));
            cur_time    = ph_base[p];
            idle_enable = (p != NUM_PHASES - 1);

            if (p == 1) begin
                // one client hammered past the saturation of its count
                {hot_upper, hot_lower} = {$urandom, $urandom, $urandom, $urandom};
                for (int n = 0; n < 260; n++) begin
                    cur_time = cur_time + 1;
                    r = '{OP_RECORD, hot_upper, hot_lower, cur_time};
                    push_request(r, 1'b0, '0);
                end
                r = '{OP_CHECK, hot_upper, hot_lower, cur_time};
                push_request(r, 1'b0, '0);
                r = '{OP_CHECK, hot_upper, hot_lower, cur_time + 1};
                push_request(r, 1'b0, '0);
            end

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p != NUM_PHASES - 1 && $urandom_range(0, 39) == 0)
                    idle_enable = !idle_enable;
                push_request(random_request(), 1'b0, '0);
                if ($urandom_range(0, 149) == 0)
                    wait_for_results();
            end
            wait_for_results();
        end

        // let anything stray come out before the verdict
        repeat (TABLE_ENTRIES + 8) @(posedge aclk);

        $display("ran %0d requests (%0d failure records) over %0d register settings",
                 requests_sent, records_sent, NUM_PHASES + 1);
        $display("checked %0d results, %0d of them reporting an active lockout",
                 results_checked, lockouts_seen);
        if (result_mismatches == 0 && pending_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches, %0d results never arrived",
                     result_mismatches, pending_results.size());
            $display("CHECK FAILED");
        end
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial begin
        #10ms;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule
